// File: hdl/csd_pkg.sv
package csd_pkg;

    localparam int CountBits = 24;
    localparam int NullBits  = CountBits - 1;
    localparam int PctBits   = 7;
    localparam int ProdBits  = NullBits + PctBits;

    localparam int QueueDepth   = 2;
    localparam int QueuePtrBits = $clog2(QueueDepth);
    localparam int QueueCntBits = $clog2(QueueDepth + 1);

    localparam logic [3:0] CsUtf32Le   = 4'd0;
    localparam logic [3:0] CsUtf32Be   = 4'd1;
    localparam logic [3:0] CsUtf8Bom   = 4'd2;
    localparam logic [3:0] CsUtf16LeBom = 4'd3;
    localparam logic [3:0] CsUtf16BeBom = 4'd4;
    localparam logic [3:0] CsGb18030   = 4'd5;
    localparam logic [3:0] CsAscii     = 4'd6;
    localparam logic [3:0] CsUtf16Le   = 4'd7;
    localparam logic [3:0] CsUtf16Be   = 4'd8;
    localparam logic [3:0] CsUtf8      = 4'd9;
    localparam logic [3:0] CsLatin1    = 4'd10;

    localparam logic [PctBits-1:0] ConfFull   = 7'd100;
    localparam logic [PctBits-1:0] ConfUtf16  = 7'd80;
    localparam logic [PctBits-1:0] ConfUtf8   = 7'd90;
    localparam logic [PctBits-1:0] ConfLatin1 = 7'd30;

    localparam logic [PctBits-1:0] Hundred = 7'd100;

    localparam logic [PctBits-1:0] MajorPctReset = 7'd30;
    localparam logic [PctBits-1:0] MinorPctReset = 7'd5;

    localparam logic [1:0] RegMajorPct = 2'd0;
    localparam logic [1:0] RegMinorPct = 2'd1;

    typedef struct packed {
        logic [7:0] byte_value;
        logic       last_byte;
    } byte_item_t;

    typedef struct packed {
        logic [3:0]         charset_code;
        logic [PctBits-1:0] confidence;
        logic [2:0]         bom_length;
    } verdict_item_t;

    typedef struct packed {
        logic [PctBits-1:0] major_pct;
        logic [PctBits-1:0] minor_pct;
    } csd_cfg_t;

    // summary of one finished buffer, handed from front to back
    typedef struct packed {
        logic [3:0]          bom_code;
        logic [2:0]          bom_len;
        logic                is_ascii;
        logic                try_utf16;
        logic                utf8_ok;
        logic [NullBits-1:0] pairs;
        logic [NullBits-1:0] even_nulls;
        logic [NullBits-1:0] odd_nulls;
    } csd_job_t;

    typedef struct packed {
        logic                    full;
        logic                    empty;
        logic [QueueCntBits-1:0] count;
    } csd_queue_status_t;

endpackage

// File: hdl/csd_front.sv
module csd_front import csd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       byte_valid,
    output logic       byte_ready,
    input  byte_item_t byte_data,
    input  logic       queue_full,
    output logic       push,
    output csd_job_t   push_job
);

    logic [31:0]          head_reg, head_next;
    logic [CountBits-1:0] total_reg, total_next;
    logic [NullBits-1:0]  even_reg, even_next;
    logic [NullBits-1:0]  odd_reg, odd_next;
    logic                 saw_null_reg, saw_null_next;
    logic                 saw_high_reg, saw_high_next;
    logic [1:0]           pend_reg, pend_next;
    logic [1:0]           len_reg, len_next;
    logic [20:0]          cp_reg, cp_next;
    logic                 inv_reg, inv_next;

    logic       accept;
    logic [7:0] b;
    logic       sat;
    logic [20:0] cp_min;

    assign byte_ready = !queue_full;
    assign accept     = byte_valid && byte_ready;
    assign b          = byte_data.byte_value;
    assign sat        = &total_reg;

    always_comb
    begin
        case (len_reg)
            2'd1:    cp_min = 21'h80;
            2'd2:    cp_min = 21'h800;
            default: cp_min = 21'h10000;
        endcase
    end

    // running statistics and UTF-8 decoder, including the current byte
    always_comb
    begin
        head_next     = head_reg;
        total_next    = total_reg;
        even_next     = even_reg;
        odd_next      = odd_reg;
        saw_null_next = saw_null_reg || (b == 8'h00);
        saw_high_next = saw_high_reg || b[7];
        pend_next     = pend_reg;
        len_next      = len_reg;
        cp_next       = cp_reg;
        inv_next      = inv_reg;

        if (total_reg < CountBits'(4))
        begin
            head_next[8*total_reg[1:0] +: 8] = b;
        end
        if (!sat && b == 8'h00)
        begin
            if (total_reg[0])
            begin
                if (!(&odd_reg))
                    odd_next = odd_reg + NullBits'(1);
            end
            else if (!byte_data.last_byte)
            begin
                if (!(&even_reg))
                    even_next = even_reg + NullBits'(1);
            end
        end
        if (!sat)
            total_next = total_reg + CountBits'(1);

        if (!inv_reg)
        begin
            if (pend_reg == 2'd0)
            begin
                if (!b[7])
                begin
                end
                else if (b[7:5] == 3'b110)
                begin
                    len_next  = 2'd1;
                    pend_next = 2'd1;
                    cp_next   = {16'd0, b[4:0]};
                end
                else if (b[7:4] == 4'b1110)
                begin
                    len_next  = 2'd2;
                    pend_next = 2'd2;
                    cp_next   = {17'd0, b[3:0]};
                end
                else if (b[7:3] == 5'b11110)
                begin
                    len_next  = 2'd3;
                    pend_next = 2'd3;
                    cp_next   = {18'd0, b[2:0]};
                end
                else
                begin
                    inv_next = 1'b1;
                end
            end
            else if (b[7:6] != 2'b10)
            begin
                inv_next = 1'b1;
            end
            else
            begin
                cp_next   = {cp_reg[14:0], b[5:0]};
                pend_next = pend_reg - 2'd1;
                if (pend_reg == 2'd1)
                begin
                    if (cp_next < cp_min || (cp_next >= 21'hD800 && cp_next <= 21'hDFFF)
                        || cp_next > 21'h10FFFF)
                        inv_next = 1'b1;
                end
            end
        end
    end

    // verdict summary from the updated values
    logic [7:0] h0, h1, h2, h3;
    logic       n4, n3, n2;

    assign h0 = head_next[7:0];
    assign h1 = head_next[15:8];
    assign h2 = head_next[23:16];
    assign h3 = head_next[31:24];
    assign n4 = total_next >= CountBits'(4);
    assign n3 = total_next >= CountBits'(3);
    assign n2 = total_next >= CountBits'(2);

    always_comb
    begin
        push_job.bom_code = CsLatin1;
        push_job.bom_len  = 3'd0;
        if (n4 && h0 == 8'hFF && h1 == 8'hFE && h2 == 8'h00 && h3 == 8'h00)
        begin
            push_job.bom_code = CsUtf32Le;
            push_job.bom_len  = 3'd4;
        end
        else if (n4 && h0 == 8'h00 && h1 == 8'h00 && h2 == 8'hFE && h3 == 8'hFF)
        begin
            push_job.bom_code = CsUtf32Be;
            push_job.bom_len  = 3'd4;
        end
        else if (n3 && h0 == 8'hEF && h1 == 8'hBB && h2 == 8'hBF)
        begin
            push_job.bom_code = CsUtf8Bom;
            push_job.bom_len  = 3'd3;
        end
        else if (n2 && h0 == 8'hFF && h1 == 8'hFE)
        begin
            push_job.bom_code = CsUtf16LeBom;
            push_job.bom_len  = 3'd2;
        end
        else if (n2 && h0 == 8'hFE && h1 == 8'hFF)
        begin
            push_job.bom_code = CsUtf16BeBom;
            push_job.bom_len  = 3'd2;
        end
        else if (n4 && h0 == 8'h84 && h1 == 8'h31 && h2 == 8'h95 && h3 == 8'h33)
        begin
            push_job.bom_code = CsGb18030;
            push_job.bom_len  = 3'd4;
        end
        push_job.is_ascii   = !saw_null_next && !saw_high_next;
        push_job.try_utf16  = saw_null_next && n4;
        push_job.utf8_ok    = !inv_next && (pend_next == 2'd0);
        push_job.pairs      = total_next[CountBits-1:1];
        push_job.even_nulls = even_next;
        push_job.odd_nulls  = odd_next;
    end

    assign push = accept && byte_data.last_byte;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg     <= '0;
            total_reg    <= '0;
            even_reg     <= '0;
            odd_reg      <= '0;
            saw_null_reg <= 1'b0;
            saw_high_reg <= 1'b0;
            pend_reg     <= '0;
            len_reg      <= '0;
            cp_reg       <= '0;
            inv_reg      <= 1'b0;
        end
        else if (accept)
        begin
            if (byte_data.last_byte)
            begin
                head_reg     <= '0;
                total_reg    <= '0;
                even_reg     <= '0;
                odd_reg      <= '0;
                saw_null_reg <= 1'b0;
                saw_high_reg <= 1'b0;
                pend_reg     <= '0;
                len_reg      <= '0;
                cp_reg       <= '0;
                inv_reg      <= 1'b0;
            end
            else
            begin
                head_reg     <= head_next;
                total_reg    <= total_next;
                even_reg     <= even_next;
                odd_reg      <= odd_next;
                saw_null_reg <= saw_null_next;
                saw_high_reg <= saw_high_next;
                pend_reg     <= pend_next;
                len_reg      <= len_next;
                cp_reg       <= cp_next;
                inv_reg      <= inv_next;
            end
        end
    end

endmodule

// File: hdl/csd_queue.sv
module csd_queue import csd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  csd_job_t          push_job,
    input  logic              pop,
    output logic              head_valid,
    output csd_job_t          head_job,
    output csd_queue_status_t status
);

    csd_job_t                entry_reg [QueueDepth];
    logic [QueuePtrBits-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QueueCntBits-1:0] count_reg, count_next;

    assign status.count = count_reg;
    assign status.full  = count_reg == QueueCntBits'(QueueDepth);
    assign status.empty = count_reg == '0;
    assign head_valid   = !status.empty;
    assign head_job     = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + QueueCntBits'(1);
        else if (pop && !push)
            count_next = count_reg - QueueCntBits'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + QueuePtrBits'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + QueuePtrBits'(1);
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_job;
    end

endmodule

// File: hdl/csd_back.sv
module csd_back import csd_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  csd_cfg_t      cfg,
    input  logic          job_valid,
    input  csd_job_t      job,
    output logic          pop,
    output logic          verdict_valid,
    input  logic          verdict_ready,
    output verdict_item_t verdict_data
);

    // stage A: threshold products
    logic                a_valid_reg;
    csd_job_t            a_job_reg;
    logic [ProdBits-1:0] major_reg, minor_reg, ev_reg, od_reg;

    // stage B: output register
    logic          o_valid_reg;
    verdict_item_t o_data_reg, o_data_next;

    logic adv_o, adv_a;

    assign adv_o = !o_valid_reg || verdict_ready;
    assign adv_a = !a_valid_reg || adv_o;
    assign pop   = job_valid && adv_a;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end
        else
        begin
            if (adv_a)
                a_valid_reg <= job_valid;
            if (adv_o)
                o_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            a_job_reg <= job;
            major_reg <= ProdBits'(cfg.major_pct) * ProdBits'(job.pairs);
            minor_reg <= ProdBits'(cfg.minor_pct) * ProdBits'(job.pairs);
            ev_reg    <= ProdBits'(job.even_nulls) * ProdBits'(Hundred);
            od_reg    <= ProdBits'(job.odd_nulls) * ProdBits'(Hundred);
        end
        if (adv_o && a_valid_reg)
            o_data_reg <= o_data_next;
    end

    always_comb
    begin
        o_data_next.charset_code = CsLatin1;
        o_data_next.confidence   = ConfLatin1;
        o_data_next.bom_length   = a_job_reg.bom_len;
        if (a_job_reg.bom_len != 3'd0)
        begin
            o_data_next.charset_code = a_job_reg.bom_code;
            o_data_next.confidence   = ConfFull;
        end
        else if (a_job_reg.is_ascii)
        begin
            o_data_next.charset_code = CsAscii;
            o_data_next.confidence   = ConfFull;
        end
        else if (a_job_reg.try_utf16 && od_reg > major_reg && ev_reg < minor_reg)
        begin
            o_data_next.charset_code = CsUtf16Le;
            o_data_next.confidence   = ConfUtf16;
        end
        else if (a_job_reg.try_utf16 && ev_reg > major_reg && od_reg < minor_reg)
        begin
            o_data_next.charset_code = CsUtf16Be;
            o_data_next.confidence   = ConfUtf16;
        end
        else if (a_job_reg.utf8_ok)
        begin
            o_data_next.charset_code = CsUtf8;
            o_data_next.confidence   = ConfUtf8;
        end
    end

    assign verdict_valid = o_valid_reg;
    assign verdict_data  = o_data_reg;

endmodule

// File: hdl/charset_stream_detector.sv
// Character set detector for a byte stream.
// Byte channel (byte_valid/byte_ready/byte_data): one byte per transfer,
// last_byte marks the final byte of a buffer. A byte is taken every cycle
// while the job queue has room.
// Verdict channel (verdict_valid/verdict_ready/verdict_data): one verdict
// per buffer: charset code, confidence and BOM length.
// The last byte's job passes the queue write, the product stage and the
// output register before verdict_valid rises. Sustained rate is one byte
// per cycle, and one verdict per cycle for one-byte buffers, while verdict_ready is high.
// Configuration: cfg_write_en with cfg_index/cfg_data writes a threshold
// percent; index 0 major, index 1 minor, other indexes ignored. Write only
// while the block is idle.
// Reset: statistics cleared, thresholds back to 30 and 5 percent, queue
// and pipeline empty.
// Receiver stall: the verdict holds in the output register; the product
// stage and the two-entry job queue fill behind it, after which byte_ready
// drops until a verdict transfer frees a slot.
module charset_stream_detector import csd_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          byte_valid,
    output logic          byte_ready,
    input  byte_item_t    byte_data,
    output logic          verdict_valid,
    input  logic          verdict_ready,
    output verdict_item_t verdict_data,
    input  logic          cfg_write_en,
    input  logic [1:0]    cfg_index,
    input  logic [6:0]    cfg_data
);

    csd_cfg_t          cfg_reg;
    logic              push, pop, head_valid;
    csd_job_t          push_job, head_job;
    csd_queue_status_t q_status;

    // threshold registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.major_pct <= MajorPctReset;
            cfg_reg.minor_pct <= MinorPctReset;
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                RegMajorPct: cfg_reg.major_pct <= cfg_data;
                RegMinorPct: cfg_reg.minor_pct <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // front: per-byte statistics, UTF-8 check, BOM match
    csd_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_ready (byte_ready),
        .byte_data  (byte_data),
        .queue_full (q_status.full),
        .push       (push),
        .push_job   (push_job)
    );

    // finished buffers wait here so front and back stall independently
    csd_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_job   (push_job),
        .pop        (pop),
        .head_valid (head_valid),
        .head_job   (head_job),
        .status     (q_status)
    );

    // back: threshold products, then priority selection of the verdict
    csd_back u_back
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg_reg),
        .job_valid     (head_valid),
        .job           (head_job),
        .pop           (pop),
        .verdict_valid (verdict_valid),
        .verdict_ready (verdict_ready),
        .verdict_data  (verdict_data)
    );

    // a BOM verdict is always one of the BOM classes at full confidence
    a_bom_class: assert property (@(posedge clk) disable iff (!rst_n)
        verdict_valid && verdict_data.bom_length != 3'd0
        |-> verdict_data.charset_code <= CsGb18030 && verdict_data.confidence == ConfFull)
        else $error("BOM verdict with wrong class or confidence");

    // statistical verdicts never carry a BOM length
    a_no_bom_len: assert property (@(posedge clk) disable iff (!rst_n)
        verdict_valid && verdict_data.charset_code >= CsAscii
        |-> verdict_data.bom_length == 3'd0 && verdict_data.charset_code <= CsLatin1)
        else $error("non-BOM verdict with BOM length or bad code");

    // a buffer end is never taken while the queue has no room
    a_queue_room: assert property (@(posedge clk) disable iff (!rst_n)
        byte_valid && byte_ready && byte_data.last_byte |-> !q_status.full)
        else $error("buffer end pushed into a full queue");

    // the queue is only popped while it holds a job, and its count stays within the queue depth
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !q_status.empty && q_status.count <= QueueCntBits'(QueueDepth))
        else $error("job queue popped while empty");

endmodule
